// ----- rtl/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Shared widths, register indexes and the word types of both channels.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // Longest pattern and width of the byte position counter.
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int OFFSET_BITS       = 32;

   // Derived widths.
   localparam int LENGTH_BITS = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int INDEX_BITS  = $clog2(MAX_PATTERN_BYTES);
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;

   // Result queue size and its pointer and count widths.
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_QPTR_BITS   = $clog2(RSP_QUEUE_DEPTH);
   localparam int RSP_QCNT_BITS   = $clog2(RSP_QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CARE_MASK      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIND_ALL       = 3'd4;

   // One input word: an image byte and its end marker.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_image;
   } req_word_type;

   // One result word: a match report or the end-of-scan summary.
   typedef struct packed {
      logic [OFFSET_BITS-1:0] match_offset;
      logic                   is_match;
      logic                   scan_done;
      logic                   any_found;
   } rsp_word_type;

endpackage

// ----- rtl/masked_byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Searches a byte stream for a masked pattern of up to sixteen bytes and
// reports match offsets and an end-of-scan summary.
// ----------------------------------------------------------------------------
// The scanner takes one image byte per cycle. Each accepted byte is shifted
// into a sixteen-byte window and compared in the same cycle against all
// pattern bytes in parallel; its results (a match report, a summary on the
// final byte, or both) are written into a four-word result queue and are
// offered on the result channel from the next cycle on. The input is stalled
// while the queue holds two or more words, so a stalled result side holds off
// new bytes once two result words are waiting, while bytes that give no result
// keep flowing; with the result side flowing the block takes one byte per
// clock while fewer than two result words are waiting. Configuration must be
// written while the scanner is idle.
module masked_byte_pattern_scanner (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input byte channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  mbps_pkg::req_word_type                 req_word,
   // Result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output mbps_pkg::rsp_word_type                 rsp_word,
   // Configuration write port
   input  logic                                   csr_write_enable,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   // Configuration registers.
   logic [63:0]                          pattern_low_ff;
   logic [63:0]                          pattern_high_ff;
   logic [mbps_pkg::MAX_PATTERN_BYTES-1:0] care_mask_ff;
   logic [mbps_pkg::LENGTH_BITS-1:0]     pattern_length_ff;
   logic                                 find_all_ff;

   // Scan state.
   logic [7:0]                           window_ff [mbps_pkg::MAX_PATTERN_BYTES];
   logic [7:0]                           window_in [mbps_pkg::MAX_PATTERN_BYTES];
   logic [mbps_pkg::OFFSET_BITS-1:0]     position_ff;
   logic [mbps_pkg::OFFSET_BITS-1:0]     position_in;
   logic                                 found_ff;
   logic                                 found_in;

   // Result queue.
   mbps_pkg::rsp_word_type               queue_ff [mbps_pkg::RSP_QUEUE_DEPTH];
   logic [mbps_pkg::RSP_QPTR_BITS-1:0]   head_ff;
   logic [mbps_pkg::RSP_QPTR_BITS-1:0]   tail_ff;
   logic [mbps_pkg::RSP_QCNT_BITS-1:0]   count_ff;
   logic [mbps_pkg::RSP_QCNT_BITS-1:0]   count_in;

   logic                                 req_accept;
   logic                                 rsp_pop;
   logic                                 window_hit;
   logic                                 report_match;
   logic [1:0]                           push_count;
   mbps_pkg::rsp_word_type               result_first;
   mbps_pkg::rsp_word_type               result_second;
   mbps_pkg::rsp_word_type               match_word;
   mbps_pkg::rsp_word_type               summary_word;
   logic [127:0]                         pattern_bits;

   // Handshakes: take a byte only while the queue holds at most one word.
   assign req_stall  = (count_ff > mbps_pkg::RSP_QCNT_BITS'(1));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_pop    = rsp_valid && !rsp_stall;
   assign rsp_word   = queue_ff[head_ff];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= '0;
         find_all_ff       <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mbps_pkg::CSR_PATTERN_LOW:    pattern_low_ff <= csr_data;
            mbps_pkg::CSR_PATTERN_HIGH:   pattern_high_ff <= csr_data;
            mbps_pkg::CSR_CARE_MASK:
               care_mask_ff <= csr_data[mbps_pkg::MAX_PATTERN_BYTES-1:0];
            mbps_pkg::CSR_PATTERN_LENGTH:
               pattern_length_ff <= csr_data[mbps_pkg::LENGTH_BITS-1:0];
            mbps_pkg::CSR_FIND_ALL:       find_all_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign pattern_bits = {pattern_high_ff, pattern_low_ff};

   // Window compare: the new byte joins the window, and every cared-for pattern
   // byte in use is checked against its window slot at the same time.
   always_comb begin
      logic [mbps_pkg::INDEX_BITS-1:0] last_slot;
      logic [mbps_pkg::INDEX_BITS-1:0] slot;
      logic                            bytes_ok;
      logic                            length_ok;
      window_in[0] = req_word.data_byte;
      for (int i = 1; i < mbps_pkg::MAX_PATTERN_BYTES; i++) begin
         window_in[i] = window_ff[i-1];
      end
      // A full-length pattern wraps the narrow index to the oldest slot.
      last_slot = pattern_length_ff[mbps_pkg::INDEX_BITS-1:0] - 1'b1;
      length_ok = (pattern_length_ff != '0) &&
                  (pattern_length_ff <= mbps_pkg::LENGTH_BITS'(mbps_pkg::MAX_PATTERN_BYTES));
      bytes_ok  = 1'b1;
      for (int k = 0; k < mbps_pkg::MAX_PATTERN_BYTES; k++) begin
         slot = last_slot - mbps_pkg::INDEX_BITS'(k);
         if ((mbps_pkg::LENGTH_BITS'(k) < pattern_length_ff) && care_mask_ff[k]) begin
            if (window_in[slot] != pattern_bits[8*k +: 8]) begin
               bytes_ok = 1'b0;
            end
         end
      end
      // The window must hold enough bytes of the current scan.
      window_hit = length_ok && bytes_ok &&
                   (position_ff >= mbps_pkg::OFFSET_BITS'(last_slot));
   end

   // Result words for this byte and the next scan state.
   always_comb begin
      report_match = window_hit && (find_all_ff || !found_ff);
      found_in     = found_ff || window_hit;

      // The match starts length minus one bytes before the current position.
      match_word.match_offset = position_ff -
         mbps_pkg::OFFSET_BITS'(pattern_length_ff) + mbps_pkg::OFFSET_BITS'(1);
      match_word.is_match     = 1'b1;
      match_word.scan_done    = 1'b0;
      match_word.any_found    = 1'b0;

      summary_word.match_offset = '0;
      summary_word.is_match     = 1'b0;
      summary_word.scan_done    = 1'b1;
      summary_word.any_found    = found_in;

      // A match found on the final byte goes out ahead of the summary.
      result_first  = report_match ? match_word : summary_word;
      result_second = summary_word;
      push_count    = 2'd0;
      if (req_accept) begin
         push_count = 2'(report_match) + 2'(req_word.end_of_image);
      end

      position_in = req_word.end_of_image ? '0 : position_ff + 1'b1;
   end

   // Window and position advance on every accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mbps_pkg::MAX_PATTERN_BYTES; i++) begin
            window_ff[i] <= '0;
         end
      end else if (req_accept) begin
         for (int i = 0; i < mbps_pkg::MAX_PATTERN_BYTES; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         found_ff    <= 1'b0;
      end else if (req_accept) begin
         position_ff <= position_in;
         found_ff    <= found_in && !req_word.end_of_image;
      end
   end

   // Result queue: up to two words written per byte, one read per cycle unless stalled.
   assign count_in = count_ff + mbps_pkg::RSP_QCNT_BITS'(push_count) -
                     mbps_pkg::RSP_QCNT_BITS'(rsp_pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[tail_ff] <= result_first;
      end
      if (push_count == 2'd2) begin
         queue_ff[tail_ff + 1'b1] <= result_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_ff + mbps_pkg::RSP_QPTR_BITS'(rsp_pop);
         tail_ff  <= tail_ff + mbps_pkg::RSP_QPTR_BITS'(push_count);
         count_ff <= count_in;
      end
   end

   // The queue never fills beyond what the input gate allows.
   assert property (@(posedge clock) disable iff (reset)
      count_ff < mbps_pkg::RSP_QCNT_BITS'(mbps_pkg::RSP_QUEUE_DEPTH))
      else $error("result queue overfilled");

   // The final byte of an image restarts position and found flag.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.end_of_image |=> (position_ff == '0) && !found_ff)
      else $error("scan state not cleared after final byte");

   // Any other byte advances the position by one.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_word.end_of_image |=>
         position_ff == $past(position_ff) + 1'b1)
      else $error("byte position did not advance");

   // In first-only mode a scan that already matched reports no more matches.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && found_ff && !find_all_ff |-> (push_count <= 2'(req_word.end_of_image)))
      else $error("repeated match reported in first-only mode");

endmodule
